// ===== rtl/core/rlsd_pkg.sv =====
// Package for the LED strip driver: command codes, widths, the gamma table
// and the video scaling function. No dependencies.
`timescale 1ns / 1ps
package rlsd_pkg;
    localparam int MAX_LEDS_DEF = 64;
    localparam int FUNC_W = 3;
    localparam logic [2:0] FN_TICK = 3'd0;
    localparam logic [2:0] FN_SET = 3'd1;
    localparam logic [2:0] FN_CLEAR = 3'd2;
    localparam logic [2:0] FN_REFRESH = 3'd3;
    localparam logic [2:0] FN_READ = 3'd4;
    localparam logic [2:0] CFG_LED_COUNT = 3'd0;
    localparam logic [2:0] CFG_BIT_TICKS = 3'd1;
    localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [2:0] CFG_ONE_HIGH = 3'd3;
    localparam logic [2:0] CFG_RESET_TICKS = 3'd4;
    localparam logic [2:0] CFG_CORR_EN = 3'd5;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] idx;
        logic       fil;
    } cmd_t;

    function automatic logic [7:0] gamma_lut(input logic [7:0] v);
        logic [7:0] t [0:255];
        t = '{
          0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,
          0,  0,  0,  0,  0,  0,  0,  0,  1,  1,  1,  1,  1,  1,  1,  2,
          2,  2,  2,  2,  2,  3,  3,  3,  3,  4,  4,  4,  4,  5,  5,  5,
          6,  6,  6,  7,  7,  7,  8,  8,  8,  9,  9, 10, 10, 10, 11, 11,
         12, 12, 13, 13, 14, 14, 15, 15, 16, 16, 17, 17, 18, 18, 19, 20,
         20, 21, 21, 22, 23, 23, 24, 25, 25, 26, 27, 28, 28, 29, 30, 31,
         31, 32, 33, 34, 35, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45,
         46, 47, 48, 49, 50, 51, 52, 54, 55, 56, 57, 58, 60, 61, 62, 64,
         65, 66, 68, 69, 70, 72, 73, 75, 76, 78, 79, 81, 82, 84, 85, 87,
         89, 90, 92, 94, 95, 97, 99,100,102,104,106,108,109,111,113,115,
        117,119,121,123,125,127,129,131,133,135,137,139,141,143,145,148,
        150,152,154,156,158,161,163,165,167,170,172,174,177,179,181,184,
        186,189,191,193,196,198,201,203,206,208,211,213,216,219,221,224,
        226,229,232,234,237,240,242,245,248,250,253,255,255,255,255,255,
        255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,
        255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,255};
        return t[v];
    endfunction

    function automatic logic [7:0] scale_video(input logic [7:0] v, input logic [7:0] k);
        logic [16:0] p;
        p = {1'b0, 16'(v) * 16'(k)} + 17'd255;
        return p[15:8];
    endfunction
endpackage

// ===== rtl/core/rlsd_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rlsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/rlsd_front.sv =====
// Front end: latches commands into a two-entry queue.
// Depends on rlsd_pkg.
`timescale 1ns / 1ps
module rlsd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rlsd_pkg::cmd_t cmd,
    input  logic           pop,
    output logic           full,
    output logic           nonempty,
    output rlsd_pkg::cmd_t head
);
    rlsd_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;
    logic push;

    assign push = start && !full;
    assign full = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign head = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cmd;
        end
    end
endmodule

// ===== rtl/core/rlsd_back.sv =====
// Back end: executes queued commands against the colour store and runs the
// serial frame timing. Depends on rlsd_pkg and rlsd_ram.
`timescale 1ns / 1ps
module rlsd_back #(
    parameter int MAX_LEDS = rlsd_pkg::MAX_LEDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           nonempty,
    input  rlsd_pkg::cmd_t head,
    output logic           pop,
    input  logic [6:0]     led_count,
    input  logic [7:0]     bit_ticks,
    input  logic [7:0]     zero_high_ticks,
    input  logic [7:0]     one_high_ticks,
    input  logic [15:0]    reset_ticks,
    input  logic           correction_enable,
    output logic           strobe,
    output logic           line_out,
    output logic           busy_res,
    output logic           pending,
    output logic           read_ok,
    output logic [7:0]     read_red,
    output logic [7:0]     read_green,
    output logic [7:0]     read_blue
);
    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1) > 7 ? $clog2(MAX_LEDS + 1) : 7;

    typedef enum logic [3:0] {
        S_DISPATCH, S_RD, S_SET_CHK, S_CORR1, S_CORR2, S_CORR3, S_WRITE,
        S_CLEAR, S_LOAD, S_EMIT, S_INIT
    } st_t;
    typedef enum logic [1:0] {PH_IDLE, PH_SEND, PH_LATCH} ph_t;

    st_t st_reg;
    ph_t ph_reg;
    logic pend_reg;
    logic [CW-1:0] led_reg;
    logic [4:0] bit_reg;
    logic [15:0] tick_reg;
    logic [23:0] shift_reg;
    logic [MAX_LEDS-1:0] mark_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0] r_reg, g_reg, b_reg;
    logic [23:0] wword_reg;
    logic ok_reg, load_pend_reg;
    logic [23:0] rdw_reg;
    logic strobe_reg;
    logic cw_we, raw_we;
    logic [23:0] cw_wdata, raw_wdata, cw_rdata, raw_rdata;
    logic [AW-1:0] ram_addr;

    logic [CW-1:0] eff;
    logic [CW:0] idx_ext;
    logic idx_ok;
    logic [7:0] period;
    logic [15:0] latch;
    logic [7:0] th;
    logic [23:0] raw_in;

    assign eff = ({1'b0, led_count} > (CW+1)'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(led_count);
    assign idx_ext = (CW+1)'(head.idx);
    assign idx_ok = idx_ext < {1'b0, eff};
    assign period = (bit_ticks == 8'd0) ? 8'd1 : bit_ticks;
    assign latch = (reset_ticks == 16'd0) ? 16'd1 : reset_ticks;
    assign th = shift_reg[23] ? one_high_ticks : zero_high_ticks;
    assign raw_in = {head.red, head.green, head.blue};

    // Pick RAM address, write enables and write data by state.
    always_comb
    begin
        ram_addr = addr_reg;
        if (st_reg == S_DISPATCH)
        begin
            ram_addr = (head.func == rlsd_pkg::FN_REFRESH) ? '0 : AW'(head.idx);
        end
        cw_we = (st_reg == S_WRITE) || (st_reg == S_CLEAR) || (st_reg == S_INIT);
        raw_we = (st_reg == S_CLEAR) || (st_reg == S_CORR1) || (st_reg == S_INIT);
        cw_wdata = ((st_reg == S_CLEAR) || (st_reg == S_INIT)) ? 24'd0 : wword_reg;
        raw_wdata = ((st_reg == S_CLEAR) || (st_reg == S_INIT)) ? 24'd0 : raw_in;
    end

    rlsd_ram #(.WIDTH(24), .DEPTH(MAX_LEDS)) u_colour (
        .clk(clk), .we(cw_we), .addr(ram_addr), .wdata(cw_wdata), .rdata(cw_rdata)
    );
    rlsd_ram #(.WIDTH(24), .DEPTH(MAX_LEDS)) u_raw (
        .clk(clk), .we(raw_we), .addr(ram_addr), .wdata(raw_wdata), .rdata(raw_rdata)
    );

    assign pop = (st_reg == S_EMIT);
    assign strobe = strobe_reg;
    assign busy_res = ph_reg != PH_IDLE;
    assign pending = pend_reg;
    assign line_out = (ph_reg == PH_SEND) && ({8'd0, th} > tick_reg);
    assign read_ok = ok_reg;
    assign read_red = rdw_reg[15:8];
    assign read_green = rdw_reg[23:16];
    assign read_blue = rdw_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_INIT;
            ph_reg <= PH_IDLE;
            pend_reg <= 1'b0;
            led_reg <= '0;
            bit_reg <= '0;
            tick_reg <= '0;
            shift_reg <= '0;
            mark_reg <= '0;
            addr_reg <= '0;
            ok_reg <= 1'b0;
            rdw_reg <= '0;
            strobe_reg <= 1'b0;
            load_pend_reg <= 1'b0;
            r_reg <= '0;
            g_reg <= '0;
            b_reg <= '0;
            wword_reg <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (st_reg)
                S_INIT:
                begin
                    // Zero both stores once after reset.
                    if (addr_reg == AW'(MAX_LEDS - 1))
                    begin
                        addr_reg <= '0;
                        st_reg <= S_DISPATCH;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                S_DISPATCH:
                begin
                    ok_reg <= 1'b0;
                    rdw_reg <= '0;
                    if (nonempty)
                    begin
                        addr_reg <= AW'(head.idx);
                        st_reg <= S_EMIT;
                        if (head.func == rlsd_pkg::FN_TICK)
                        begin
                            if (ph_reg == PH_SEND)
                            begin
                                if (tick_reg + 16'd1 >= {8'd0, period})
                                begin
                                    tick_reg <= '0;
                                    shift_reg <= {shift_reg[22:0], 1'b0};
                                    if (bit_reg == 5'd23)
                                    begin
                                        bit_reg <= '0;
                                        led_reg <= led_reg + 1'b1;
                                        if (led_reg + 1'b1 >= eff)
                                        begin
                                            pend_reg <= 1'b0;
                                            ph_reg <= PH_LATCH;
                                        end
                                        else
                                        begin
                                            addr_reg <= AW'(led_reg + 1'b1);
                                            load_pend_reg <= 1'b1;
                                            st_reg <= S_LOAD;
                                        end
                                    end
                                    else
                                    begin
                                        bit_reg <= bit_reg + 5'd1;
                                    end
                                end
                                else
                                begin
                                    tick_reg <= tick_reg + 16'd1;
                                end
                            end
                            else if (ph_reg == PH_LATCH)
                            begin
                                if (tick_reg + 16'd1 >= latch)
                                begin
                                    ph_reg <= PH_IDLE;
                                    tick_reg <= '0;
                                end
                                else
                                begin
                                    tick_reg <= tick_reg + 16'd1;
                                end
                            end
                        end
                        else if (ph_reg == PH_IDLE)
                        begin
                            priority case (head.func)
                                rlsd_pkg::FN_SET:
                                begin
                                    if (idx_ok)
                                    begin
                                        st_reg <= S_SET_CHK;
                                    end
                                end
                                rlsd_pkg::FN_CLEAR:
                                begin
                                    pend_reg <= 1'b1;
                                    addr_reg <= '0;
                                    if (eff != '0)
                                    begin
                                        st_reg <= S_CLEAR;
                                    end
                                end
                                rlsd_pkg::FN_REFRESH:
                                begin
                                    if (pend_reg)
                                    begin
                                        led_reg <= '0;
                                        bit_reg <= '0;
                                        tick_reg <= '0;
                                        if (eff == '0)
                                        begin
                                            shift_reg <= '0;
                                            pend_reg <= 1'b0;
                                            ph_reg <= PH_LATCH;
                                        end
                                        else
                                        begin
                                            ph_reg <= PH_SEND;
                                            addr_reg <= '0;
                                            load_pend_reg <= 1'b1;
                                            st_reg <= S_LOAD;
                                        end
                                    end
                                end
                                rlsd_pkg::FN_READ:
                                begin
                                    if (idx_ok)
                                    begin
                                        st_reg <= S_RD;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                S_RD:
                begin
                    ok_reg <= 1'b1;
                    rdw_reg <= cw_rdata;
                    st_reg <= S_EMIT;
                end
                S_SET_CHK:
                begin
                    if (!head.fil || !correction_enable)
                    begin
                        if (!head.fil)
                        begin
                            mark_reg[addr_reg] <= 1'b0;
                        end
                        wword_reg <= {head.green, head.red, head.blue};
                        st_reg <= (cw_rdata == {head.green, head.red, head.blue})
                            ? S_EMIT : S_WRITE;
                    end
                    else if (mark_reg[addr_reg] && raw_rdata == raw_in)
                    begin
                        st_reg <= S_EMIT;
                    end
                    else
                    begin
                        r_reg <= rlsd_pkg::gamma_lut(head.red);
                        g_reg <= rlsd_pkg::gamma_lut(head.green);
                        b_reg <= rlsd_pkg::gamma_lut(head.blue);
                        wword_reg <= cw_rdata;
                        st_reg <= S_CORR1;
                    end
                end
                S_CORR1:
                begin
                    mark_reg[addr_reg] <= 1'b1;
                    g_reg <= rlsd_pkg::scale_video(g_reg, 8'd176);
                    b_reg <= rlsd_pkg::scale_video(b_reg, 8'd240);
                    st_reg <= S_CORR2;
                end
                S_CORR2:
                begin
                    r_reg <= rlsd_pkg::scale_video(r_reg, 8'd32);
                    g_reg <= rlsd_pkg::scale_video(g_reg, 8'd32);
                    b_reg <= rlsd_pkg::scale_video(b_reg, 8'd32);
                    st_reg <= S_CORR3;
                end
                S_CORR3:
                begin
                    // Old stored word sits in wword_reg.
                    st_reg <= (wword_reg == {g_reg, r_reg, b_reg}) ? S_EMIT : S_WRITE;
                    wword_reg <= {g_reg, r_reg, b_reg};
                end
                S_WRITE:
                begin
                    pend_reg <= 1'b1;
                    st_reg <= S_EMIT;
                end
                S_CLEAR:
                begin
                    mark_reg[addr_reg] <= 1'b0;
                    if (CW'(addr_reg) + 1'b1 >= eff)
                    begin
                        st_reg <= S_EMIT;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                S_LOAD:
                begin
                    // RAM read of the next word lands once load_pend_reg has cleared.
                    if (load_pend_reg)
                    begin
                        load_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        shift_reg <= cw_rdata;
                        st_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    strobe_reg <= 1'b1;
                    st_reg <= S_DISPATCH;
                end
                default:
                begin
                    st_reg <= S_DISPATCH;
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/rgb_led_strip_driver_unit.sv =====
// Top level of the LED strip driver: configuration registers, command
// queue and executor. Depends on rlsd_pkg, rlsd_front, rlsd_back.
// One command at a time: dispatch, then as needed a load of the next LED or
// first frame word, a read, a set check with S_CORR1 to S_CORR3 and a write,
// or a clear of each LED in use, then emit. Reset: asynchronous; a pass over
// all MAX_LEDS addresses then zeroes both stores. busy is high while full.
`timescale 1ns / 1ps
module rgb_led_strip_driver_unit #(
    parameter int MAX_LEDS = rlsd_pkg::MAX_LEDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  pixel_index,
    input  logic        filament_mode,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        strobe,
    output logic        line_out,
    output logic        busy_res,
    output logic        pending,
    output logic        read_ok,
    output logic [7:0]  read_red,
    output logic [7:0]  read_green,
    output logic [7:0]  read_blue
);
    logic [6:0] led_count_reg;
    logic [7:0] bit_ticks_reg, zero_high_reg, one_high_reg;
    logic [15:0] reset_ticks_reg;
    logic corr_en_reg;
    rlsd_pkg::cmd_t cmd, head;
    logic pop, full, nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= 7'd0;
            bit_ticks_reg <= 8'd22;
            zero_high_reg <= 8'd7;
            one_high_reg <= 8'd15;
            reset_ticks_reg <= 16'd14400;
            corr_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlsd_pkg::CFG_LED_COUNT: led_count_reg <= cfg_data[6:0];
                rlsd_pkg::CFG_BIT_TICKS: bit_ticks_reg <= cfg_data[7:0];
                rlsd_pkg::CFG_ZERO_HIGH: zero_high_reg <= cfg_data[7:0];
                rlsd_pkg::CFG_ONE_HIGH: one_high_reg <= cfg_data[7:0];
                rlsd_pkg::CFG_RESET_TICKS: reset_ticks_reg <= cfg_data;
                rlsd_pkg::CFG_CORR_EN: corr_en_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cmd = '{func: func, red: red_in, green: green_in, blue: blue_in,
                   idx: pixel_index, fil: filament_mode};
    assign busy = full;

    rlsd_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .pop(pop),
        .full(full), .nonempty(nonempty), .head(head)
    );

    rlsd_back #(.MAX_LEDS(MAX_LEDS)) u_back (
        .clk(clk), .rst_n(rst_n), .nonempty(nonempty), .head(head), .pop(pop),
        .led_count(led_count_reg), .bit_ticks(bit_ticks_reg),
        .zero_high_ticks(zero_high_reg), .one_high_ticks(one_high_reg),
        .reset_ticks(reset_ticks_reg), .correction_enable(corr_en_reg),
        .strobe(strobe), .line_out(line_out), .busy_res(busy_res),
        .pending(pending), .read_ok(read_ok), .read_red(read_red),
        .read_green(read_green), .read_blue(read_blue)
    );

    a_pop_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> strobe) else $error("pop without result");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty) else $error("pop from empty queue");
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !read_ok) |-> (read_red == 8'd0 && read_blue == 8'd0))
        else $error("read data without read_ok");
endmodule

// ===== tb/sv/rgb_led_strip_driver_unit_test.sv =====
// Self-checking testbench for the LED strip driver: a queue-fed driver, a strobe monitor
// and a request-by-request predictor of store, refresh flag and frame timing.
// Depends on rlsd_pkg and rgb_led_strip_driver_unit.
`timescale 1ns / 1ps
module rgb_led_strip_driver_unit_test;
    typedef enum logic [1:0] {ST_IDLE, ST_SEND, ST_LATCH} strip_phase_e;

    typedef struct packed {
        logic       line;
        logic       busy;
        logic       pend;
        logic       ok;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } strip_resp_t;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int ITEM_TARGET = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  func = rlsd_pkg::FN_TICK;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic [7:0]  pixel_index = '0;
    logic        filament_mode = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = rlsd_pkg::CFG_LED_COUNT;
    logic [15:0] cfg_data = '0;
    logic        strobe;
    logic        line_out;
    logic        busy_res;
    logic        pending;
    logic        read_ok;
    logic [7:0]  read_red;
    logic [7:0]  read_green;
    logic [7:0]  read_blue;

    rgb_led_strip_driver_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .pixel_index(pixel_index), .filament_mode(filament_mode),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .strobe(strobe), .line_out(line_out), .busy_res(busy_res),
        .pending(pending), .read_ok(read_ok), .read_red(read_red),
        .read_green(read_green), .read_blue(read_blue)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gamma curve for filament colours
    byte unsigned gamma_curve [256] = '{
          0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,
          0,  0,  0,  0,  0,  0,  0,  0,  1,  1,  1,  1,  1,  1,  1,  2,
          2,  2,  2,  2,  2,  3,  3,  3,  3,  4,  4,  4,  4,  5,  5,  5,
          6,  6,  6,  7,  7,  7,  8,  8,  8,  9,  9, 10, 10, 10, 11, 11,
         12, 12, 13, 13, 14, 14, 15, 15, 16, 16, 17, 17, 18, 18, 19, 20,
         20, 21, 21, 22, 23, 23, 24, 25, 25, 26, 27, 28, 28, 29, 30, 31,
         31, 32, 33, 34, 35, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45,
         46, 47, 48, 49, 50, 51, 52, 54, 55, 56, 57, 58, 60, 61, 62, 64,
         65, 66, 68, 69, 70, 72, 73, 75, 76, 78, 79, 81, 82, 84, 85, 87,
         89, 90, 92, 94, 95, 97, 99,100,102,104,106,108,109,111,113,115,
        117,119,121,123,125,127,129,131,133,135,137,139,141,143,145,148,
        150,152,154,156,158,161,163,165,167,170,172,174,177,179,181,184,
        186,189,191,193,196,198,201,203,206,208,211,213,216,219,221,224,
        226,229,232,234,237,240,242,245,248,250,253,255,255,255,255,255,
        255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,
        255,255,255,255,255,255,255,255,255,255,255,255,255,255,255,255};

    // predictor state
    logic [6:0]   p_count = 7'd0;
    logic [7:0]   p_bit_ticks = 8'd22;
    logic [7:0]   p_zero_high = 8'd7;
    logic [7:0]   p_one_high = 8'd15;
    logic [15:0]  p_latch_ticks = 16'd14400;
    logic         p_corr = 1'b1;
    logic [23:0]  grb_store [64];
    logic [23:0]  raw_store [64];
    logic         fil_mark [64];
    logic         p_pend = 1'b0;
    strip_phase_e p_phase = ST_IDLE;
    int unsigned  p_led = 0;
    int unsigned  p_bit = 0;
    int unsigned  p_tick = 0;
    logic [23:0]  p_shift = '0;

    rlsd_pkg::cmd_t req_q [$];
    strip_resp_t    resp_q [$];
    rlsd_pkg::cmd_t cur_req;
    bit          req_taken = 0;
    int          idle_pct = 0;
    int          errors = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_frames = 0;
    int          n_cmds = 0;
    int          n_items = 0;
    int          n_phases = 0;
    int          quiet = 0;

    initial begin
        for (int i = 0; i < 64; i++) begin
            grb_store[i] = '0;
            raw_store[i] = '0;
            fil_mark[i] = 1'b0;
        end
    end

    function automatic int unsigned leds_in_use();
        return (p_count > 7'd64) ? 64 : int'(p_count);
    endfunction

    function automatic logic [7:0] scale8(int unsigned v, int unsigned k);
        int unsigned p;
        p = (v * k + 255) >> 8;
        return p[7:0];
    endfunction

    function automatic void store_grb(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      int unsigned idx);
        logic [23:0] packed_c;
        packed_c = {g, r, b};
        if (grb_store[idx] != packed_c) begin
            grb_store[idx] = packed_c;
            p_pend = 1'b1;
        end
    endfunction

    function automatic void enter_latch();
        p_pend = 1'b0;
        p_phase = ST_LATCH;
        p_tick = 0;
    endfunction

    function automatic void advance_tick();
        int unsigned period;
        int unsigned latch;
        period = (p_bit_ticks == 0) ? 1 : p_bit_ticks;
        latch = (p_latch_ticks == 0) ? 1 : p_latch_ticks;
        if (p_phase == ST_SEND) begin
            p_tick++;
            if (p_tick >= period) begin
                p_tick = 0;
                p_shift = p_shift << 1;
                p_bit++;
                if (p_bit >= 24) begin
                    p_bit = 0;
                    p_led++;
                    if (p_led >= leds_in_use()) enter_latch();
                    else p_shift = (p_led < 64) ? grb_store[p_led] : '0;
                end
            end
        end else if (p_phase == ST_LATCH) begin
            p_tick++;
            if (p_tick >= latch) begin
                p_phase = ST_IDLE;
                p_tick = 0;
            end
        end
    endfunction

    function automatic void apply_set(rlsd_pkg::cmd_t c);
        int unsigned idx;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [23:0] raw;
        idx = c.idx;
        if (idx >= leds_in_use()) return;
        if (!c.fil) begin
            fil_mark[idx] = 1'b0;
            store_grb(c.red, c.green, c.blue, idx);
            return;
        end
        if (!p_corr) begin
            store_grb(c.red, c.green, c.blue, idx);
            return;
        end
        raw = {c.red, c.green, c.blue};
        if (fil_mark[idx] && raw_store[idx] == raw) return;
        fil_mark[idx] = 1'b1;
        raw_store[idx] = raw;
        r = gamma_curve[c.red];
        g = scale8(gamma_curve[c.green], 176);
        b = scale8(gamma_curve[c.blue], 240);
        store_grb(scale8(r, 32), scale8(g, 32), scale8(b, 32), idx);
    endfunction

    function automatic strip_resp_t strip_step(rlsd_pkg::cmd_t c);
        strip_resp_t res;
        logic [23:0] rd_word;
        logic [7:0]  th;
        res = '0;
        rd_word = '0;
        if (c.func == rlsd_pkg::FN_TICK) begin
            advance_tick();
        end else if (p_phase == ST_IDLE) begin
            case (c.func)
                rlsd_pkg::FN_SET: apply_set(c);
                rlsd_pkg::FN_CLEAR: begin
                    for (int i = 0; i < leds_in_use(); i++) begin
                        grb_store[i] = '0;
                        raw_store[i] = '0;
                        fil_mark[i] = 1'b0;
                    end
                    p_pend = 1'b1;
                end
                rlsd_pkg::FN_REFRESH: begin
                    if (p_pend) begin
                        p_led = 0;
                        p_bit = 0;
                        p_tick = 0;
                        n_frames++;
                        if (leds_in_use() == 0) begin
                            p_shift = '0;
                            enter_latch();
                        end else begin
                            p_shift = grb_store[0];
                            p_phase = ST_SEND;
                        end
                    end
                end
                rlsd_pkg::FN_READ: begin
                    if (c.idx < leds_in_use()) begin
                        res.ok = 1'b1;
                        rd_word = grb_store[c.idx];
                    end
                end
                default: ;
            endcase
        end
        th = p_shift[23] ? p_one_high : p_zero_high;
        res.line = (p_phase == ST_SEND) && (p_tick < th);
        res.busy = (p_phase != ST_IDLE);
        res.pend = p_pend;
        res.g = rd_word[23:16];
        res.r = rd_word[15:8];
        res.b = rd_word[7:0];
        return res;
    endfunction

    // driver: present requests at the falling edge
    always @(negedge clk) begin
        if (!start || req_taken) begin
            if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur_req = req_q.pop_front();
                start <= 1'b1;
                func <= cur_req.func;
                red_in <= cur_req.red;
                green_in <= cur_req.green;
                blue_in <= cur_req.blue;
                pixel_index <= cur_req.idx;
                filament_mode <= cur_req.fil;
            end else begin
                start <= 1'b0;
            end
        end
        req_taken = 0;
    end

    always @(posedge clk) begin
        if (rst_n && start && !busy) begin
            resp_q.push_back(strip_step(cur_req));
            req_taken = 1;
            n_accepted++;
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor: results cannot be held off, so check every strobe
    always @(posedge clk) begin
        strip_resp_t e;
        if (rst_n && (strobe || (start && !busy))) quiet = 0;
        else quiet++;
        if (rst_n && strobe) begin
            if (resp_q.size() == 0) begin
                $display("%0t ns: result with no request outstanding", $time);
                errors++;
            end else begin
                e = resp_q.pop_front();
                check_field("line_out", e.line, line_out);
                check_field("busy_res", e.busy, busy_res);
                check_field("pending", e.pend, pending);
                check_field("read_ok", e.ok, read_ok);
                check_field("read_red", e.r, read_red);
                check_field("read_green", e.g, read_green);
                check_field("read_blue", e.b, read_blue);
                n_checked++;
            end
        end
    end

    initial begin
        while (quiet < QUIET_LIMIT) @(posedge clk);
        $display("%0t ns: timeout, no progress", $time);
        $display("Some tests failed");
        $finish;
    end

    task automatic push_req(logic [2:0] f, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] idx, logic fil);
        rlsd_pkg::cmd_t c;
        c.func = f;
        c.red = r;
        c.green = g;
        c.blue = b;
        c.idx = idx;
        c.fil = fil;
        req_q.push_back(c);
        n_items++;
        if (f != rlsd_pkg::FN_TICK) n_cmds++;
    endtask

    task automatic push_rand(logic [2:0] f);
        push_req(f, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (req_q.size() != 0 || start || resp_q.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            rlsd_pkg::CFG_LED_COUNT: p_count = v[6:0];
            rlsd_pkg::CFG_BIT_TICKS: p_bit_ticks = v[7:0];
            rlsd_pkg::CFG_ZERO_HIGH: p_zero_high = v[7:0];
            rlsd_pkg::CFG_ONE_HIGH: p_one_high = v[7:0];
            rlsd_pkg::CFG_RESET_TICKS: p_latch_ticks = v;
            rlsd_pkg::CFG_CORR_EN: p_corr = v[0];
            default: ;
        endcase
    endtask

    // hold requests until idle, then reprogram every register
    task automatic set_config(int cnt, int bt, int zh, int oh, int rt, int ce);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(rlsd_pkg::CFG_LED_COUNT, 16'(cnt));
        write_reg(rlsd_pkg::CFG_BIT_TICKS, 16'(bt));
        write_reg(rlsd_pkg::CFG_ZERO_HIGH, 16'(zh));
        write_reg(rlsd_pkg::CFG_ONE_HIGH, 16'(oh));
        write_reg(rlsd_pkg::CFG_RESET_TICKS, 16'(rt));
        write_reg(rlsd_pkg::CFG_CORR_EN, 16'(ce));
        @(negedge clk);
        cfg_we <= 1'b0;
        n_phases++;
        idle_pct = (n_phases % 3 == 0) ? 0 : ((n_phases % 3 == 1) ? 46 : 13);
    endtask

    task automatic push_ticks(int len);
        for (int i = 0; i < len; i++) begin
            // drop in a few commands that must be ignored while the frame runs
            if ($urandom_range(99) < 2)
                push_rand(3'($urandom_range(rlsd_pkg::FN_SET, 7)));
            else
                push_rand(rlsd_pkg::FN_TICK);
        end
    endtask

    task automatic push_frame();
        int len;
        len = leds_in_use() * 24 * p_bit_ticks + p_latch_ticks + 4;
        push_rand(rlsd_pkg::FN_REFRESH);
        push_ticks(len);
    endtask

    task automatic pick_idx(output logic [7:0] idx);
        int n;
        n = leds_in_use();
        if (n == 0 || $urandom_range(9) == 0) idx = 8'($urandom);
        else idx = 8'($urandom_range(n - 1));
    endtask

    task automatic fill_random(int n_ops);
        logic [7:0] idx;
        logic [7:0] r, g, b;
        int k;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        for (int i = 0; i < n_ops; i++) begin
            k = $urandom_range(99);
            pick_idx(idx);
            if ($urandom_range(4) != 0) begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
            if (k < 40) push_req(rlsd_pkg::FN_SET, r, g, b, idx, 1'($urandom));
            else if (k < 65) push_req(rlsd_pkg::FN_READ, r, g, b, idx, 1'($urandom));
            else if (k < 69) push_req(rlsd_pkg::FN_CLEAR, r, g, b, idx, 1'($urandom));
            else if (k < 73) push_req(3'($urandom_range(5, 7)), r, g, b, idx, 1'($urandom));
            else if (k < 75) push_frame();
            else push_req(rlsd_pkg::FN_TICK, r, g, b, idx, 1'($urandom));
        end
        push_frame();
        for (int i = 0; i < 8; i++) begin
            pick_idx(idx);
            push_req(rlsd_pkg::FN_READ, 8'h00, 8'h00, 8'h00, idx, 1'b0);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: full strip, two-tick bits and a one-tick latch
        set_config(64, 2, 1, 1, 1, 1);
        push_req(rlsd_pkg::FN_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_req(rlsd_pkg::FN_SET, 8'hff, 8'hff, 8'hff, 8'd0, 1'b0);
        push_req(rlsd_pkg::FN_SET, 8'hff, 8'hff, 8'hff, 8'd0, 1'b0);
        push_req(rlsd_pkg::FN_SET, 8'h00, 8'h00, 8'h01, 8'd63, 1'b0);
        push_req(rlsd_pkg::FN_SET, 8'h12, 8'h34, 8'h56, 8'd64, 1'b0);
        push_req(rlsd_pkg::FN_SET, 8'hff, 8'h80, 8'h01, 8'd1, 1'b1);
        push_req(rlsd_pkg::FN_SET, 8'hff, 8'h80, 8'h01, 8'd1, 1'b1);
        push_req(rlsd_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0);
        push_req(rlsd_pkg::FN_SET, 8'h5a, 8'ha5, 8'h3c, 8'd1, 1'b0);
        push_req(rlsd_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        push_req(rlsd_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'd63, 1'b0);
        push_req(rlsd_pkg::FN_READ, 8'hff, 8'hff, 8'hff, 8'd255, 1'b1);
        push_req(3'd5, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        push_req(3'd7, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
        push_req(rlsd_pkg::FN_TICK, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        // start a frame, then lower the LED count while the second LED is in flight
        push_req(rlsd_pkg::FN_REFRESH, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        push_ticks(60);
        set_config(2, 2, 1, 1, 1, 1);
        push_frame();
        push_req(rlsd_pkg::FN_REFRESH, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        push_req(rlsd_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0);

        // correction off, then high time covering the whole bit
        set_config(2, 2, 1, 2, 5, 0);
        push_req(rlsd_pkg::FN_SET, 8'h80, 8'h40, 8'h20, 8'd1, 1'b1);
        push_req(rlsd_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0);
        fill_random(30);
        set_config(1, 4, 4, 4, 3, 1);
        push_req(rlsd_pkg::FN_SET, 8'h01, 8'h02, 8'h03, 8'd0, 1'b0);
        push_frame();
        // no LEDs: refresh goes straight to the latch; zero latch time acts as one
        set_config(0, 22, 7, 15, 0, 1);
        push_req(rlsd_pkg::FN_CLEAR, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        push_req(rlsd_pkg::FN_SET, 8'h01, 8'h02, 8'h03, 8'd0, 1'b0);
        push_frame();
        set_config(3, 2, 1, 3, 2, 1);
        fill_random(20);

        while (n_items < ITEM_TARGET) begin
            set_config($urandom_range(1, 3), $urandom_range(2, 3), $urandom_range(1, 3),
                       $urandom_range(1, 3), $urandom_range(1, 8), $urandom_range(1));
            fill_random(20);
        end
        set_config(2, 2, 1, 255, 1, 1);
        fill_random(16);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d configuration phases, %0d requests (%0d commands), %0d frames.",
                 n_phases, n_accepted, n_cmds, n_frames);
        $display("Checked %0d results against the predicted line, flags and read-back.",
                 n_checked);
        if (errors == 0 && resp_q.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
